>>> hdl/lens_distortion_index_map_macros.svh
// ----------------------------------------------------------------------------
// Lens distortion index map assertion macros
// Shared concurrent assertion forms for the index map pipeline.
// ----------------------------------------------------------------------------
`ifndef LENS_DISTORTION_INDEX_MAP_MACROS_SVH
`define LENS_DISTORTION_INDEX_MAP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LDIM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lens distortion index map: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LDIM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lens distortion index map: assertion failed");

`endif

>>> hdl/ldim_pkg.sv
// ----------------------------------------------------------------------------
// Lens distortion index map package
// Image geometry, register codes, the configuration bundle and the
// saturation helpers shared by the index map modules.
// ----------------------------------------------------------------------------
package ldim_pkg;

  localparam int IMG_WIDTH  = 512;
  localparam int IMG_HEIGHT = 424;

  localparam int PIX_W   = 9;
  localparam int IDX_W   = 18;
  localparam int DIST_W  = 26;
  localparam int COORD_W = 24;
  localparam int CFG_W   = 48;
  localparam int REG_W   = 3;

  // Fourteen datapath stages and the output register.
  localparam int NUM_STAGES = 15;

  typedef enum logic [REG_W-1:0] {
    REG_FOCAL_XY       = 3'd0,
    REG_RECIP_FOCAL_XY = 3'd1,
    REG_CENTER_XY      = 3'd2,
    REG_RADIAL_K1      = 3'd3,
    REG_RADIAL_K2      = 3'd4,
    REG_RADIAL_K3      = 3'd5,
    REG_TANGENTIAL_P1  = 3'd6,
    REG_TANGENTIAL_P2  = 3'd7
  } ldim_reg_e;

  typedef struct packed {
    logic [COORD_W-1:0] fx;
    logic [COORD_W-1:0] fy;
    logic [COORD_W-1:0] rfx;
    logic [COORD_W-1:0] rfy;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic signed [31:0] k1;
    logic signed [31:0] k2;
    logic signed [31:0] k3;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
  } ldim_cfg_t;

  localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
  localparam logic signed [65:0] S32_MIN = -66'sd2147483648;
  localparam logic signed [65:0] S26_MAX = 66'sd33554431;
  localparam logic signed [65:0] S26_MIN = -66'sd33554432;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < S32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Returns the saturation flag above the 26-bit saturated value.
  function automatic logic [DIST_W:0] sat26(input logic signed [65:0] v);
    logic [DIST_W:0] r;
    if (v > S26_MAX) begin
      r = {1'b1, S26_MAX[DIST_W-1:0]};
    end else if (v < S26_MIN) begin
      r = {1'b1, S26_MIN[DIST_W-1:0]};
    end else begin
      r = {1'b0, v[DIST_W-1:0]};
    end
    return r;
  endfunction

endpackage

>>> hdl/lens_distortion_index_map.sv
// ----------------------------------------------------------------------------
// Lens distortion index map
// Maps an undistorted pixel coordinate to its distorted source coordinate
// and its linear index in the raw image.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one pixel coordinate (pix_x_i, pix_y_i) per beat
// and the output channel one result per beat: the valid flag, the linear
// source index and the distorted coordinates in Q13.12. Both channels use a
// valid/ready handshake. One beat can be accepted in every clock cycle while
// the output is not stalled, so the sustained throughput is one coordinate per
// cycle. The pipeline has fifteen register stages: fourteen distortion stages
// (a multiply or a shift, add and saturate per stage) and the output register.
// The whole pipeline advances together: while a result waits at the output
// and the receiver holds ready low, in_ready_o is low and every stage holds
// its contents. Reset clears all stage valid flags and all configuration
// registers to zero. Configuration is written through the plain write port;
// the user must do so while no beats are in flight; the block does not check.
// ----------------------------------------------------------------------------
module lens_distortion_index_map (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ldim_pkg::REG_W-1:0]         cfg_idx_i,
  input  logic [ldim_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [ldim_pkg::PIX_W-1:0]         pix_x_i,
  input  logic [ldim_pkg::PIX_W-1:0]         pix_y_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               src_valid_o,
  output logic [ldim_pkg::IDX_W-1:0]         src_index_o,
  output logic signed [ldim_pkg::DIST_W-1:0] dist_x_o,
  output logic signed [ldim_pkg::DIST_W-1:0] dist_y_o
);

  localparam int CW = ldim_pkg::COORD_W;

  ldim_pkg::ldim_cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (ldim_pkg::ldim_reg_e'(cfg_idx_i))
        ldim_pkg::REG_FOCAL_XY: begin
          cfg_d.fx = cfg_wdata_i[CW-1:0];
          cfg_d.fy = cfg_wdata_i[2*CW-1:CW];
        end
        ldim_pkg::REG_RECIP_FOCAL_XY: begin
          cfg_d.rfx = cfg_wdata_i[CW-1:0];
          cfg_d.rfy = cfg_wdata_i[2*CW-1:CW];
        end
        ldim_pkg::REG_CENTER_XY: begin
          cfg_d.cx = cfg_wdata_i[CW-1:0];
          cfg_d.cy = cfg_wdata_i[2*CW-1:CW];
        end
        ldim_pkg::REG_RADIAL_K1:     cfg_d.k1 = $signed(cfg_wdata_i[31:0]);
        ldim_pkg::REG_RADIAL_K2:     cfg_d.k2 = $signed(cfg_wdata_i[31:0]);
        ldim_pkg::REG_RADIAL_K3:     cfg_d.k3 = $signed(cfg_wdata_i[31:0]);
        ldim_pkg::REG_TANGENTIAL_P1: cfg_d.p1 = $signed(cfg_wdata_i[31:0]);
        ldim_pkg::REG_TANGENTIAL_P2: cfg_d.p2 = $signed(cfg_wdata_i[31:0]);
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ldim_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pix_x_i     (pix_x_i),
    .pix_y_i     (pix_y_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .src_valid_o (src_valid_o),
    .src_index_o (src_index_o),
    .dist_x_o    (dist_x_o),
    .dist_y_o    (dist_y_o)
  );

endmodule

>>> hdl/ldim_pipe.sv
// ----------------------------------------------------------------------------
// Lens distortion index map pipeline
// Fixed-point radial and tangential distortion, rounding and index
// calculation in fifteen register stages with a common stall enable.
// ----------------------------------------------------------------------------
`include "lens_distortion_index_map_macros.svh"

module ldim_pipe (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ldim_pkg::ldim_cfg_t              cfg_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [ldim_pkg::PIX_W-1:0]       pix_x_i,
  input  logic [ldim_pkg::PIX_W-1:0]       pix_y_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             src_valid_o,
  output logic [ldim_pkg::IDX_W-1:0]       src_index_o,
  output logic signed [ldim_pkg::DIST_W-1:0] dist_x_o,
  output logic signed [ldim_pkg::DIST_W-1:0] dist_y_o
);

  localparam int NS = ldim_pkg::NUM_STAGES;
  localparam int DW = ldim_pkg::DIST_W;

  localparam logic [14:0] W15 = 15'(ldim_pkg::IMG_WIDTH);
  localparam logic [14:0] H15 = 15'(ldim_pkg::IMG_HEIGHT);
  localparam logic signed [DW-1:0] VLD_LO = -26'sd6144;
  localparam logic signed [DW-1:0] VLD_X_HI = 26'(ldim_pkg::IMG_WIDTH * 4096 - 2048);
  localparam logic signed [DW-1:0] VLD_Y_HI = 26'(ldim_pkg::IMG_HEIGHT * 4096 - 2048);

  logic          en;
  logic [NS-1:0] v_d, v_q;

  assign en         = !v_q[NS-1] || out_ready_i;
  assign in_ready_o = en;
  assign out_valid_o = v_q[NS-1];
  assign v_d        = {v_q[NS-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= v_d;
    end
  end

  logic signed [24:0] ux, uy;
  logic signed [49:0] s1_px_q, s1_py_q;
  logic signed [31:0] s2_dx_q, s2_dy_q;
  logic signed [63:0] s3_dxx_q, s3_dyy_q, s3_dxy_q;
  logic signed [31:0] s3_dx_q, s3_dy_q;
  logic signed [31:0] dx2_c, dy2_c;
  logic signed [31:0] s4_dx_q, s4_dy_q, s4_dx2_q, s4_dy2_q, s4_r2_q, s4_q_q;
  logic signed [63:0] s5_k3r2_q;
  logic signed [31:0] s5_dx_q, s5_dy_q, s5_r2_q, s5_q_q, s5_sx_q, s5_sy_q;
  logic signed [31:0] s6_t1_q, s6_dx_q, s6_dy_q, s6_r2_q, s6_q_q, s6_sx_q, s6_sy_q;
  logic signed [63:0] s7_t1r2_q;
  logic signed [31:0] s7_dx_q, s7_dy_q, s7_r2_q, s7_q_q, s7_sx_q, s7_sy_q;
  logic signed [31:0] s8_t2_q, s8_dx_q, s8_dy_q, s8_r2_q, s8_q_q, s8_sx_q, s8_sy_q;
  logic signed [63:0] s9_t2r2_q;
  logic signed [31:0] s9_dx_q, s9_dy_q, s9_q_q, s9_sx_q, s9_sy_q;
  logic signed [31:0] s10_kr_q, s10_dx_q, s10_dy_q, s10_q_q, s10_sx_q, s10_sy_q;
  logic signed [63:0] s11_xa_q, s11_xb_q, s11_xc_q, s11_ya_q, s11_yb_q, s11_yc_q;
  logic signed [31:0] s12_nx_q, s12_ny_q;
  logic signed [56:0] s13_fxn_q, s13_fyn_q;
  logic [DW:0]        satx_c, saty_c;
  logic signed [DW-1:0] s14_x_q, s14_y_q;
  logic               s14_satx_q, s14_saty_q;

  assign ux = $signed({2'b00, pix_x_i, 14'd0}) - $signed({1'b0, cfg_i.cx});
  assign uy = $signed({2'b00, pix_y_i, 14'd0}) - $signed({1'b0, cfg_i.cy});

  assign dx2_c = ldim_pkg::sat32(66'(s3_dxx_q >>> 24));
  assign dy2_c = ldim_pkg::sat32(66'(s3_dyy_q >>> 24));

  assign satx_c = ldim_pkg::sat26((66'(s13_fxn_q) + $signed({20'd0, cfg_i.cx, 22'd0})) >>> 24);
  assign saty_c = ldim_pkg::sat26((66'(s13_fyn_q) + $signed({20'd0, cfg_i.cy, 22'd0})) >>> 24);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_px_q <= ux * $signed({1'b0, cfg_i.rfx});
      s1_py_q <= uy * $signed({1'b0, cfg_i.rfy});

      s2_dx_q <= ldim_pkg::sat32(66'(s1_px_q >>> 14));
      s2_dy_q <= ldim_pkg::sat32(66'(s1_py_q >>> 14));

      s3_dxx_q <= s2_dx_q * s2_dx_q;
      s3_dyy_q <= s2_dy_q * s2_dy_q;
      s3_dxy_q <= s2_dx_q * s2_dy_q;
      s3_dx_q  <= s2_dx_q;
      s3_dy_q  <= s2_dy_q;

      s4_dx2_q <= dx2_c;
      s4_dy2_q <= dy2_c;
      s4_r2_q  <= ldim_pkg::sat32(66'(dx2_c) + 66'(dy2_c));
      s4_q_q   <= ldim_pkg::sat32(66'(s3_dxy_q >>> 24) <<< 1);
      s4_dx_q  <= s3_dx_q;
      s4_dy_q  <= s3_dy_q;

      s5_k3r2_q <= cfg_i.k3 * s4_r2_q;
      s5_sx_q   <= ldim_pkg::sat32(66'(s4_r2_q) + (66'(s4_dx2_q) <<< 1));
      s5_sy_q   <= ldim_pkg::sat32(66'(s4_r2_q) + (66'(s4_dy2_q) <<< 1));
      s5_dx_q   <= s4_dx_q;
      s5_dy_q   <= s4_dy_q;
      s5_r2_q   <= s4_r2_q;
      s5_q_q    <= s4_q_q;

      s6_t1_q <= ldim_pkg::sat32((66'(s5_k3r2_q) + (66'($signed(cfg_i.k2)) <<< 24)) >>> 28);
      s6_dx_q <= s5_dx_q;
      s6_dy_q <= s5_dy_q;
      s6_r2_q <= s5_r2_q;
      s6_q_q  <= s5_q_q;
      s6_sx_q <= s5_sx_q;
      s6_sy_q <= s5_sy_q;

      s7_t1r2_q <= s6_t1_q * s6_r2_q;
      s7_dx_q   <= s6_dx_q;
      s7_dy_q   <= s6_dy_q;
      s7_r2_q   <= s6_r2_q;
      s7_q_q    <= s6_q_q;
      s7_sx_q   <= s6_sx_q;
      s7_sy_q   <= s6_sy_q;

      s8_t2_q <= ldim_pkg::sat32((66'(s7_t1r2_q) + (66'($signed(cfg_i.k1)) <<< 20)) >>> 24);
      s8_dx_q <= s7_dx_q;
      s8_dy_q <= s7_dy_q;
      s8_r2_q <= s7_r2_q;
      s8_q_q  <= s7_q_q;
      s8_sx_q <= s7_sx_q;
      s8_sy_q <= s7_sy_q;

      s9_t2r2_q <= s8_t2_q * s8_r2_q;
      s9_dx_q   <= s8_dx_q;
      s9_dy_q   <= s8_dy_q;
      s9_q_q    <= s8_q_q;
      s9_sx_q   <= s8_sx_q;
      s9_sy_q   <= s8_sy_q;

      s10_kr_q <= ldim_pkg::sat32(66'sd16777216 + (66'(s9_t2r2_q) >>> 24));
      s10_dx_q <= s9_dx_q;
      s10_dy_q <= s9_dy_q;
      s10_q_q  <= s9_q_q;
      s10_sx_q <= s9_sx_q;
      s10_sy_q <= s9_sy_q;

      s11_xa_q <= s10_dx_q * s10_kr_q;
      s11_xb_q <= cfg_i.p2 * s10_sx_q;
      s11_xc_q <= cfg_i.p1 * s10_q_q;
      s11_ya_q <= s10_dy_q * s10_kr_q;
      s11_yb_q <= cfg_i.p1 * s10_sy_q;
      s11_yc_q <= cfg_i.p2 * s10_q_q;

      s12_nx_q <= ldim_pkg::sat32((66'(s11_xa_q) >>> 24) + (66'(s11_xb_q) >>> 28)
                                  + (66'(s11_xc_q) >>> 28));
      s12_ny_q <= ldim_pkg::sat32((66'(s11_ya_q) >>> 24) + (66'(s11_yb_q) >>> 28)
                                  + (66'(s11_yc_q) >>> 28));

      s13_fxn_q <= $signed({1'b0, cfg_i.fx}) * s12_nx_q;
      s13_fyn_q <= $signed({1'b0, cfg_i.fy}) * s12_ny_q;

      s14_satx_q <= satx_c[DW];
      s14_saty_q <= saty_c[DW];
      s14_x_q    <= $signed(satx_c[DW-1:0]);
      s14_y_q    <= $signed(saty_c[DW-1:0]);
    end
  end

  // Round half up by adding one half and truncating toward zero.
  logic signed [DW:0] rx, ry;
  logic [13:0]        ix, iy;
  logic               x_in, y_in, valid_c;
  logic [27:0]        lin;

  assign rx = 27'(s14_x_q) + 27'sd2048;
  assign ry = 27'(s14_y_q) + 27'sd2048;
  assign ix = rx[DW] ? 14'd0 : rx[DW-1:12];
  assign iy = ry[DW] ? 14'd0 : ry[DW-1:12];
  assign x_in = rx[DW] ? (rx > -27'sd4096) : ({1'b0, ix} < W15);
  assign y_in = ry[DW] ? (ry > -27'sd4096) : ({1'b0, iy} < H15);
  assign valid_c = !s14_satx_q && !s14_saty_q && x_in && y_in;
  assign lin = 28'(iy) * 28'(ldim_pkg::IMG_WIDTH) + 28'(ix);

  always_ff @(posedge clk_i) begin
    if (en) begin
      src_valid_o <= valid_c;
      src_index_o <= valid_c ? lin[ldim_pkg::IDX_W-1:0] : '0;
      dist_x_o    <= s14_x_q;
      dist_y_o    <= s14_y_q;
    end
  end

  `LDIM_ASSERT_IMP(a_invalid_index_zero, clk_i, rst_ni, out_valid_o && !src_valid_o, src_index_o == '0)
  `LDIM_ASSERT_IMP(a_valid_x_range, clk_i, rst_ni, out_valid_o && src_valid_o, dist_x_o > VLD_LO && dist_x_o < VLD_X_HI)
  `LDIM_ASSERT_IMP(a_valid_y_range, clk_i, rst_ni, out_valid_o && src_valid_o, dist_y_o > VLD_LO && dist_y_o < VLD_Y_HI)
  `LDIM_ASSERT_NXT(a_beat_enters, clk_i, rst_ni, in_valid_i && in_ready_o, v_q[0])

endmodule

>>> tb/sv/ldim_map_checker.sv
// ----------------------------------------------------------------------------
// Lens distortion index map checker
// Watches the configuration port and both handshake channels of the index
// map. Every accepted input beat is run through a fixed-point model of the
// radial and tangential lens distortion, and every accepted output beat is
// compared field by field with the oldest predicted source mapping.
// ----------------------------------------------------------------------------
module ldim_map_checker
  import ldim_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [REG_W-1:0]           cfg_idx_i,
  input  logic [CFG_W-1:0]           cfg_wdata_i,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [PIX_W-1:0]           pix_x_i,
  input  logic [PIX_W-1:0]           pix_y_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic                       src_valid_i,
  input  logic [IDX_W-1:0]           src_index_i,
  input  logic signed [DIST_W-1:0]   dist_x_i,
  input  logic signed [DIST_W-1:0]   dist_y_i,
  output int                         fail_count_o,
  output int                         pending_o,
  output int                         results_o,
  output int                         inside_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PIX_W-1:0]         px;
    logic [PIX_W-1:0]         py;
    logic                     src_valid;
    logic [IDX_W-1:0]         src_index;
    logic signed [DIST_W-1:0] dist_x;
    logic signed [DIST_W-1:0] dist_y;
  } src_map_t;

  localparam longint Q20   = 64'sd1 <<< 20;
  localparam longint Q22   = 64'sd1 <<< 22;
  localparam longint Q24   = 64'sd1 <<< 24;
  localparam longint D_MAX = (64'sd1 <<< 25) - 1;
  localparam longint D_MIN = -(64'sd1 <<< 25);

  ldim_cfg_t lens_cfg = '0;
  src_map_t  expected_maps[$];
  int        fails = 0;
  int        seen = 0;
  int        in_image = 0;

  assign fail_count_o = fails;
  assign pending_o    = expected_maps.size();
  assign results_o    = seen;
  assign inside_o     = in_image;

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Adds one half and truncates toward zero.
  function automatic longint nearest_pixel(input longint q12);
    longint v;
    v = q12 + 2048;
    return (v >= 0) ? (v >>> 12) : -((-v) >>> 12);
  endfunction

  function automatic src_map_t distort_pixel(input logic [PIX_W-1:0] col,
                                             input logic [PIX_W-1:0] row);
    longint fx, fy, rfx, rfy, cx, cy, k1, k2, k3, p1, p2;
    longint dx, dy, dx2, dy2, r2, q, t1, t2, kr, sx, sy, nx, ny, xs, ys, ix, iy;
    bit clipped;
    src_map_t m;
    fx  = longint'(lens_cfg.fx);
    fy  = longint'(lens_cfg.fy);
    rfx = longint'(lens_cfg.rfx);
    rfy = longint'(lens_cfg.rfy);
    cx  = longint'(lens_cfg.cx);
    cy  = longint'(lens_cfg.cy);
    k1  = longint'($signed(lens_cfg.k1));
    k2  = longint'($signed(lens_cfg.k2));
    k3  = longint'($signed(lens_cfg.k3));
    p1  = longint'($signed(lens_cfg.p1));
    p2  = longint'($signed(lens_cfg.p2));

    dx  = clamp32(((longint'(col) * 16384 - cx) * rfx) >>> 14);
    dy  = clamp32(((longint'(row) * 16384 - cy) * rfy) >>> 14);
    dx2 = clamp32((dx * dx) >>> 24);
    dy2 = clamp32((dy * dy) >>> 24);
    r2  = clamp32(dx2 + dy2);
    q   = clamp32(2 * ((dx * dy) >>> 24));
    t1  = clamp32((k3 * r2 + k2 * Q24) >>> 28);
    t2  = clamp32((t1 * r2 + k1 * Q20) >>> 24);
    kr  = clamp32(Q24 + ((t2 * r2) >>> 24));
    sx  = clamp32(r2 + 2 * dx2);
    sy  = clamp32(r2 + 2 * dy2);
    nx  = clamp32(((dx * kr) >>> 24) + ((p2 * sx) >>> 28) + ((p1 * q) >>> 28));
    ny  = clamp32(((dy * kr) >>> 24) + ((p1 * sy) >>> 28) + ((p2 * q) >>> 28));
    xs  = (fx * nx + cx * Q22) >>> 24;
    ys  = (fy * ny + cy * Q22) >>> 24;

    clipped = 1'b0;
    if (xs > D_MAX) begin
      xs = D_MAX;
      clipped = 1'b1;
    end else if (xs < D_MIN) begin
      xs = D_MIN;
      clipped = 1'b1;
    end
    if (ys > D_MAX) begin
      ys = D_MAX;
      clipped = 1'b1;
    end else if (ys < D_MIN) begin
      ys = D_MIN;
      clipped = 1'b1;
    end

    ix = nearest_pixel(xs);
    iy = nearest_pixel(ys);
    m.px        = col;
    m.py        = row;
    m.src_valid = !clipped && ix >= 0 && ix < IMG_WIDTH && iy >= 0 && iy < IMG_HEIGHT;
    m.src_index = m.src_valid ? IDX_W'(iy * IMG_WIDTH + ix) : '0;
    m.dist_x    = DIST_W'(xs);
    m.dist_y    = DIST_W'(ys);
    return m;
  endfunction

  task automatic report_mismatch(input string what, input src_map_t want,
                                 input longint got_v, input longint want_v);
    $display("[%0t] mismatch on result %0d, pixel (%0d,%0d): %s is %0d, expected %0d",
             $time, seen, want.px, want.py, what, got_v, want_v);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    src_map_t want;
    if (!rst_ni) begin
      lens_cfg = '0;
      expected_maps.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        seen++;
        if (expected_maps.size() == 0) begin
          report_mismatch("result beat with nothing outstanding", '0, 1, 0);
        end else begin
          want = expected_maps.pop_front();
          if (src_valid_i !== want.src_valid)
            report_mismatch("src_valid", want, src_valid_i, want.src_valid);
          if (src_index_i !== want.src_index)
            report_mismatch("src_index", want, src_index_i, want.src_index);
          if (dist_x_i !== want.dist_x)
            report_mismatch("dist_x", want, dist_x_i, want.dist_x);
          if (dist_y_i !== want.dist_y)
            report_mismatch("dist_y", want, dist_y_i, want.dist_y);
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_maps.push_back(distort_pixel(pix_x_i, pix_y_i));
        if (expected_maps[$].src_valid) in_image++;
      end
      if (cfg_we_i) begin
        case (ldim_reg_e'(cfg_idx_i))
          REG_FOCAL_XY:       {lens_cfg.fy, lens_cfg.fx} = cfg_wdata_i;
          REG_RECIP_FOCAL_XY: {lens_cfg.rfy, lens_cfg.rfx} = cfg_wdata_i;
          REG_CENTER_XY:      {lens_cfg.cy, lens_cfg.cx} = cfg_wdata_i;
          REG_RADIAL_K1:      lens_cfg.k1 = cfg_wdata_i[31:0];
          REG_RADIAL_K2:      lens_cfg.k2 = cfg_wdata_i[31:0];
          REG_RADIAL_K3:      lens_cfg.k3 = cfg_wdata_i[31:0];
          REG_TANGENTIAL_P1:  lens_cfg.p1 = cfg_wdata_i[31:0];
          REG_TANGENTIAL_P2:  lens_cfg.p2 = cfg_wdata_i[31:0];
          default: ;
        endcase
      end
    end
  end

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Lens distortion index map testbench
// Loads a series of lens settings, from identity and realistic lenses to
// saturating extremes and random values, and streams pixel coordinates
// through the index map with bursty input and a stalling receiver. The
// checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ldim_pkg::*;

  localparam logic [COORD_W-1:0] F_365   = 24'd1495040;
  localparam logic [COORD_W-1:0] F_730   = 24'd2990080;
  localparam logic [COORD_W-1:0] RF_365  = 24'd45965;
  localparam logic [COORD_W-1:0] CX_MID  = 24'd4194304;
  localparam logic [COORD_W-1:0] CY_MID  = 24'd3473408;
  localparam logic [COORD_W-1:0] C_FRAC  = 24'd10240;
  localparam logic [COORD_W-1:0] C_FULL  = 24'hFF_FFFF;
  localparam logic signed [31:0] K_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] K_MIN   = 32'sh8000_0000;
  localparam int                 HOLD_CYCLES = 80;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [REG_W-1:0]           cfg_idx_i;
  logic [CFG_W-1:0]           cfg_wdata_i;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic [PIX_W-1:0]           pix_x_i;
  logic [PIX_W-1:0]           pix_y_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic                       src_valid_o;
  logic [IDX_W-1:0]           src_index_o;
  logic signed [DIST_W-1:0]   dist_x_o;
  logic signed [DIST_W-1:0]   dist_y_o;

  int mismatches;
  int maps_pending;
  int maps_seen;
  int maps_inside;
  int lens_settings = 0;
  bit hold_off_req = 1'b0;

  lens_distortion_index_map uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pix_x_i     (pix_x_i),
    .pix_y_i     (pix_y_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .src_valid_o (src_valid_o),
    .src_index_o (src_index_o),
    .dist_x_o    (dist_x_o),
    .dist_y_o    (dist_y_o)
  );

  ldim_map_checker map_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .pix_x_i      (pix_x_i),
    .pix_y_i      (pix_y_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .src_valid_i  (src_valid_o),
    .src_index_i  (src_index_o),
    .dist_x_i     (dist_x_o),
    .dist_y_i     (dist_y_o),
    .fail_count_o (mismatches),
    .pending_o    (maps_pending),
    .results_o    (maps_seen),
    .inside_o     (maps_inside)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Run timed out with %0d results outstanding.", maps_pending);
    $display("== FAIL ==");
    $finish;
  end

  // The receiver switches between stall styles on its own schedule and
  // holds off completely once when asked.
  initial begin : receiver
    int seg_left;
    int style;
    int hold_left;
    bit hold_done;
    seg_left  = 0;
    style     = 0;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          style    = $urandom_range(0, 3);
          seg_left = $urandom_range(16, 160);
        end
        seg_left--;
        case (style)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 3) != 0);
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= ~out_ready_i;
        endcase
      end
    end
  end

  task automatic write_reg(input ldim_reg_e idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic load_lens(input ldim_cfg_t c);
    write_reg(REG_FOCAL_XY, {c.fy, c.fx});
    write_reg(REG_RECIP_FOCAL_XY, {c.rfy, c.rfx});
    write_reg(REG_CENTER_XY, {c.cy, c.cx});
    write_reg(REG_RADIAL_K1, {16'($urandom), c.k1});
    write_reg(REG_RADIAL_K2, {16'($urandom), c.k2});
    write_reg(REG_RADIAL_K3, {16'($urandom), c.k3});
    write_reg(REG_TANGENTIAL_P1, {16'($urandom), c.p1});
    write_reg(REG_TANGENTIAL_P2, {16'($urandom), c.p2});
    lens_settings++;
  endtask

  task automatic load_random_lens(input bit wild);
    ldim_cfg_t c;
    int unsigned f;
    if (wild) begin
      c.fx  = 24'($urandom);
      c.fy  = 24'($urandom);
      c.rfx = 24'($urandom);
      c.rfy = 24'($urandom);
      c.cx  = 24'($urandom);
      c.cy  = 24'($urandom);
      c.k1  = $urandom;
      c.k2  = $urandom;
      c.k3  = $urandom;
      c.p1  = $urandom;
      c.p2  = $urandom;
    end else begin
      f     = $urandom_range(200, 600);
      c.fx  = 24'(f * 4096 + $urandom_range(0, 4095));
      c.rfx = 24'(32'd16777216 / f);
      f     = $urandom_range(200, 600);
      c.fy  = 24'(f * 4096 + $urandom_range(0, 4095));
      c.rfy = 24'(32'd16777216 / f);
      c.cx  = 24'($urandom_range(3276800, 5111808));
      c.cy  = 24'($urandom_range(2457600, 4489216));
      c.k1  = int'($urandom_range(0, 268435456)) - 134217728;
      c.k2  = int'($urandom_range(0, 268435456)) - 134217728;
      c.k3  = int'($urandom_range(0, 268435456)) - 134217728;
      c.p1  = int'($urandom_range(0, 8388608)) - 4194304;
      c.p2  = int'($urandom_range(0, 8388608)) - 4194304;
    end
    load_lens(c);
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    pix_x_i    <= x;
    pix_y_i    <= y;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  // Lowers valid, waits for every outstanding result and lets the
  // pipeline settle so the registers can be rewritten.
  task automatic drain;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (maps_pending != 0) @(negedge clk_i);
    repeat (NUM_STAGES + 5) @(negedge clk_i);
  endtask

  task automatic send_random_pixels(input int count, input bit gaps_on);
    int burst;
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 48);
        if (gaps_on) pause_sender($urandom_range(1, 10));
      end
      burst--;
      x = $urandom_range(0, 511);
      y = ($urandom_range(0, 9) == 0) ? $urandom_range(424, 511) : $urandom_range(0, 423);
      if ($urandom_range(0, 15) == 0) x = $urandom_range(0, 1) ? 9'd511 : 9'd0;
      if ($urandom_range(0, 15) == 0) y = $urandom_range(0, 1) ? 9'd423 : 9'd0;
      send_pixel(x, y);
    end
    drain();
  endtask

  initial begin : stimulus
    ldim_cfg_t identity_lens;
    ldim_cfg_t real_lens;
    ldim_cfg_t scaled_lens;
    ldim_cfg_t strong_lens;
    ldim_cfg_t max_lens;
    ldim_cfg_t min_lens;

    identity_lens = '{F_365, F_365, RF_365, RF_365, CX_MID, CY_MID, 0, 0, 0, 0, 0};
    real_lens     = '{F_365, F_365, RF_365, RF_365, CX_MID, CY_MID,
                      32'sd24159191, -32'sd72477573, 32'sd24159191,
                      32'sd268435, -32'sd134218};
    scaled_lens   = '{F_730, F_730, RF_365, RF_365, C_FRAC, C_FRAC, 0, 0, 0, 0, 0};
    strong_lens   = '{F_365, F_365, RF_365, RF_365, CX_MID, CY_MID,
                      -32'sd161061274, 32'sd107374182, -32'sd53687091,
                      32'sd5368709, -32'sd5368709};
    max_lens      = '{C_FULL, C_FULL, C_FULL, C_FULL, C_FULL, C_FULL,
                      K_MAX, K_MAX, K_MAX, K_MAX, K_MAX};
    min_lens      = '{C_FULL, C_FULL, C_FULL, C_FULL, 24'd0, 24'd0,
                      K_MIN, K_MIN, K_MIN, K_MIN, K_MIN};

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_FOCAL_XY;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    pix_x_i     = '0;
    pix_y_i     = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Registers still at reset: zero reciprocal focal lengths.
    send_pixel(9'd0, 9'd0);
    send_pixel(9'd511, 9'd511);
    drain();

    load_lens(identity_lens);
    send_pixel(9'd0, 9'd0);
    send_pixel(9'd511, 9'd423);
    send_pixel(9'd256, 9'd212);
    send_pixel(9'd511, 9'd0);
    drain();

    // Doubled focal length about a fractional center puts points just
    // left of zero, right at the last column and row, and just outside.
    load_lens(scaled_lens);
    send_pixel(9'd0, 9'd0);
    send_pixel(9'd1, 9'd1);
    send_pixel(9'd255, 9'd211);
    send_pixel(9'd256, 9'd212);
    send_pixel(9'd257, 9'd213);
    send_pixel(9'd0, 9'd212);
    send_pixel(9'd256, 9'd0);
    send_pixel(9'd511, 9'd511);
    drain();

    load_lens(max_lens);
    send_pixel(9'd0, 9'd0);
    send_pixel(9'd511, 9'd511);
    send_pixel(9'd300, 9'd100);
    drain();

    load_lens(min_lens);
    send_pixel(9'd0, 9'd0);
    send_pixel(9'd511, 9'd423);
    send_pixel(9'd100, 9'd400);
    drain();

    load_lens(identity_lens);
    send_random_pixels(150, 1'b1);
    load_lens(real_lens);
    send_random_pixels(250, 1'b1);
    load_lens(scaled_lens);
    send_random_pixels(150, 1'b1);

    // The receiver holds off while the sender keeps offering beats.
    load_lens(strong_lens);
    hold_off_req = 1'b1;
    send_random_pixels(200, 1'b0);

    repeat (4) begin
      load_random_lens(1'b0);
      send_random_pixels(150, $urandom_range(0, 1));
    end
    repeat (2) begin
      load_random_lens(1'b1);
      send_random_pixels(100, 1'b1);
    end
    load_lens(max_lens);
    send_random_pixels(50, 1'b1);
    load_lens(min_lens);
    send_random_pixels(50, 1'b1);
    load_lens(real_lens);
    send_random_pixels(150, 1'b0);

    $display("Mapped %0d pixel beats under %0d lens settings, %0d of them inside the image.",
             maps_seen, lens_settings, maps_inside);
    $display("Settings ranged from identity and real lenses to saturating extremes.");
    if (mismatches == 0 && maps_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
